/* rtl/core/mpr_pkg.sv */
`default_nettype none
package mpr_pkg;

   localparam int unsigned MAX_PREFIX_BITS = 128;

   localparam logic [3:0] CLS_AFI       = 4'd0;
   localparam logic [3:0] CLS_SAFI      = 4'd1;
   localparam logic [3:0] CLS_HOP_LEN   = 4'd2;
   localparam logic [3:0] CLS_HOP       = 4'd3;
   localparam logic [3:0] CLS_LOCAL_HOP = 4'd4;
   localparam logic [3:0] CLS_SNPA_CNT  = 4'd5;
   localparam logic [3:0] CLS_SNPA_LEN  = 4'd6;
   localparam logic [3:0] CLS_SNPA_BYTE = 4'd7;
   localparam logic [3:0] CLS_PFX_LEN   = 4'd8;
   localparam logic [3:0] CLS_PFX_BYTE  = 4'd9;
   localparam logic [3:0] CLS_DISCARD   = 4'd10;
   localparam logic [3:0] CLS_OTHER_HOP = 4'd11;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_PFX_LONG  = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;

   typedef enum logic [13:0] {
      PH_IDLE     = 14'b00000000000001,
      PH_AFI0     = 14'b00000000000010,
      PH_AFI1     = 14'b00000000000100,
      PH_SAFI     = 14'b00000000001000,
      PH_HOPLEN   = 14'b00000000010000,
      PH_HOP      = 14'b00000000100000,
      PH_LOCAL    = 14'b00000001000000,
      PH_OTHER    = 14'b00000010000000,
      PH_SNPACNT  = 14'b00000100000000,
      PH_SNPALEN  = 14'b00001000000000,
      PH_SNPABYTE = 14'b00010000000000,
      PH_PFXLEN   = 14'b00100000000000,
      PH_PFXBYTE  = 14'b01000000000000,
      PH_DISCARD  = 14'b10000000000000
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_attribute;
      logic [15:0] attribute_length;
   } req_type;

   typedef struct packed {
      logic [3:0]  byte_class;
      logic [4:0]  index_in_field;
      logic [15:0] afi_value;
      logic [7:0]  safi_value;
      logic [7:0]  prefix_bits;
      logic        field_last;
      logic        short_form;
      logic [1:0]  error_code;
      logic        attribute_done;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/core/mpr_parser.sv */
`default_nettype none
module mpr_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire mpr_pkg::req_type item,
   output mpr_pkg::rsp_type     result
);
   import mpr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  field_pos_ff, field_pos_in;
   logic [7:0]  field_size_ff, field_size_in;
   logic [7:0]  snpa_left_ff, snpa_left_in;
   logic [15:0] afi_ff, afi_in;
   logic [7:0]  safi_ff, safi_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic        short_ff, short_in;
   logic [1:0]  error_ff, error_in;
   logic        hop_local_ff, hop_local_in;

   always_comb begin
      logic [7:0] b;
      logic [8:0] next_pos;
      logic       hit;
      logic [3:0] cls;
      logic [7:0] idx;
      logic       last;
      logic       done;
      b             = item.data_byte;
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      field_pos_in  = field_pos_ff;
      field_size_in = field_size_ff;
      snpa_left_in  = snpa_left_ff;
      afi_in        = afi_ff;
      safi_in       = safi_ff;
      prefix_in     = prefix_ff;
      short_in      = short_ff;
      error_in      = error_ff;
      hop_local_in  = hop_local_ff;
      cls           = CLS_DISCARD;
      idx           = 8'd0;
      last          = 1'b0;
      done          = 1'b0;

      if (item.start_of_attribute) begin
         bytes_left_in = (item.attribute_length == 16'd0) ? 16'd1 : item.attribute_length;
         field_pos_in  = 8'd0;
         field_size_in = 8'd0;
         snpa_left_in  = 8'd0;
         afi_in        = 16'd0;
         safi_in       = 8'd0;
         prefix_in     = 8'd0;
         error_in      = ERR_NONE;
         hop_local_in  = 1'b0;
         short_in      = ({1'b0, bytes_left_in} == ({9'd0, b} + 17'd1));
         phase_in      = short_in ? PH_HOPLEN : PH_AFI0;
      end

      next_pos = {1'b0, field_pos_in} + 9'd1;
      hit      = next_pos >= {1'b0, field_size_in};

      if (phase_in != PH_IDLE) begin
         case (phase_in)
            PH_AFI0: begin
               cls      = CLS_AFI;
               afi_in   = {b, 8'd0};
               phase_in = PH_AFI1;
            end
            PH_AFI1: begin
               cls      = CLS_AFI;
               idx      = 8'd1;
               last     = 1'b1;
               afi_in   = {afi_in[15:8], b};
               phase_in = PH_SAFI;
            end
            PH_SAFI: begin
               cls      = CLS_SAFI;
               last     = 1'b1;
               safi_in  = b;
               phase_in = PH_HOPLEN;
            end
            PH_HOPLEN: begin
               cls          = CLS_HOP_LEN;
               last         = 1'b1;
               field_pos_in = 8'd0;
               hop_local_in = (b == 8'd32);
               if (b == 8'd0) begin
                  phase_in = short_in ? PH_DISCARD : PH_SNPACNT;
               end else if (b inside {8'd4, 8'd16}) begin
                  phase_in      = PH_HOP;
                  field_size_in = b;
               end else if (b == 8'd32) begin
                  phase_in      = PH_HOP;
                  field_size_in = 8'd16;
               end else begin
                  phase_in      = PH_OTHER;
                  field_size_in = b;
               end
            end
            PH_HOP: begin
               cls          = CLS_HOP;
               idx          = field_pos_in;
               field_pos_in = hit ? 8'd0 : next_pos[7:0];
               if (hit) begin
                  last = 1'b1;
                  if (hop_local_in) begin
                     hop_local_in  = 1'b0;
                     phase_in      = PH_LOCAL;
                     field_size_in = 8'd16;
                  end else begin
                     phase_in = short_in ? PH_DISCARD : PH_SNPACNT;
                  end
               end
            end
            PH_LOCAL, PH_OTHER: begin
               cls          = (phase_in == PH_LOCAL) ? CLS_LOCAL_HOP : CLS_OTHER_HOP;
               idx          = field_pos_in;
               field_pos_in = hit ? 8'd0 : next_pos[7:0];
               if (hit) begin
                  last     = 1'b1;
                  phase_in = short_in ? PH_DISCARD : PH_SNPACNT;
               end
            end
            PH_SNPACNT: begin
               cls          = CLS_SNPA_CNT;
               last         = 1'b1;
               snpa_left_in = b;
               phase_in     = (b != 8'd0) ? PH_SNPALEN : PH_PFXLEN;
            end
            PH_SNPALEN: begin
               cls  = CLS_SNPA_LEN;
               last = 1'b1;
               if (b != 8'd0) begin
                  phase_in      = PH_SNPABYTE;
                  field_size_in = b;
                  field_pos_in  = 8'd0;
               end else begin
                  snpa_left_in = snpa_left_in - 8'd1;
                  phase_in     = (snpa_left_in != 8'd0) ? PH_SNPALEN : PH_PFXLEN;
               end
            end
            PH_SNPABYTE: begin
               cls          = CLS_SNPA_BYTE;
               idx          = field_pos_in;
               field_pos_in = hit ? 8'd0 : next_pos[7:0];
               if (hit) begin
                  last         = 1'b1;
                  snpa_left_in = snpa_left_in - 8'd1;
                  phase_in     = (snpa_left_in != 8'd0) ? PH_SNPALEN : PH_PFXLEN;
               end
            end
            PH_PFXLEN: begin
               cls       = CLS_PFX_LEN;
               prefix_in = b;
               if ({1'b0, b} > 9'(MAX_PREFIX_BITS)) begin
                  error_in = ERR_PFX_LONG;
                  phase_in = PH_DISCARD;
               end else if (b == 8'd0) begin
                  last = 1'b1;
               end else begin
                  phase_in      = PH_PFXBYTE;
                  field_size_in = 8'(({1'b0, b} + 9'd7) >> 3);
                  field_pos_in  = 8'd0;
               end
            end
            PH_PFXBYTE: begin
               cls          = CLS_PFX_BYTE;
               idx          = field_pos_in;
               field_pos_in = hit ? 8'd0 : next_pos[7:0];
               if (hit) begin
                  last     = 1'b1;
                  phase_in = PH_PFXLEN;
               end
            end
            default: begin
               cls = CLS_DISCARD;
            end
         endcase

         bytes_left_in = bytes_left_in - 16'd1;
         if (bytes_left_in == 16'd0) begin
            done = 1'b1;
            if (phase_in != PH_PFXLEN && phase_in != PH_DISCARD && error_in == ERR_NONE) begin
               error_in = ERR_TRUNCATED;
            end
            phase_in = PH_IDLE;
         end
      end

      result.byte_class     = cls;
      result.index_in_field = idx[4:0];
      result.afi_value      = afi_in;
      result.safi_value     = safi_in;
      result.prefix_bits    = prefix_in;
      result.field_last     = last;
      result.short_form     = short_in;
      result.error_code     = error_in;
      result.attribute_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= 16'd0;
         field_pos_ff  <= 8'd0;
         field_size_ff <= 8'd0;
         snpa_left_ff  <= 8'd0;
         afi_ff        <= 16'd0;
         safi_ff       <= 8'd0;
         prefix_ff     <= 8'd0;
         short_ff      <= 1'b0;
         error_ff      <= ERR_NONE;
         hop_local_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         field_pos_ff  <= field_pos_in;
         field_size_ff <= field_size_in;
         snpa_left_ff  <= snpa_left_in;
         afi_ff        <= afi_in;
         safi_ff       <= safi_in;
         prefix_ff     <= prefix_in;
         short_ff      <= short_in;
         error_ff      <= error_in;
         hop_local_ff  <= hop_local_in;
      end
   end

   a_idle_no_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bytes_left_ff == 16'd0))
      else $error("idle with bytes outstanding");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step && result.attribute_done) |=> (phase_ff == PH_IDLE))
      else $error("attribute end did not return to idle");

   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HOP || phase_ff == PH_LOCAL || phase_ff == PH_OTHER
       || phase_ff == PH_SNPABYTE || phase_ff == PH_PFXBYTE)
      |-> (field_pos_ff < field_size_ff))
      else $error("field position past field size");

endmodule
`default_nettype wire

/* rtl/core/mpr_rsp_stage.sv */
`default_nettype none
module mpr_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire mpr_pkg::rsp_type  load_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mpr_pkg::rsp_type      rsp_data
);
   import mpr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

/* rtl/core/mp_reach_attribute_parser_core.sv */
`default_nettype none
// Byte-serial multiprotocol reach attribute value parser. Each transfer on req_ carries one
// byte of the value (start_of_attribute and attribute_length on the first byte) and
// yields exactly one rsp_ transfer classifying that byte, in order. One byte per clock
// is sustained while rsp_stall is low. Each byte passes through the input register, then
// the parse step into the result register, before its rsp_ transfer. Throughput is set
// by the single per-byte state update loop.
module mp_reach_attribute_parser_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mpr_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mpr_pkg::rsp_type      rsp_data
);
   import mpr_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_free;
   logic    advance;
   logic    req_take;
   rsp_type step_result;

   assign advance     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
   end

   mpr_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_data_ff),
      .result (step_result)
   );

   mpr_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid))
      else $error("input stalled without a held item");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared with no item in the input register");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code <= ERR_TRUNCATED))
      else $error("illegal error code");

   a_discard_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_class == CLS_DISCARD) |-> !rsp_data.field_last)
      else $error("discarded byte marked as field end");

endmodule
`default_nettype wire

/* tb/mp_reach_attribute_parser_checker.sv */
`default_nettype none
module mp_reach_attribute_parser_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire mpr_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire mpr_pkg::rsp_type rsp_data,
   output int                    fails,
   output int                    pending
);
   import mpr_pkg::*;

   rsp_type     classified_q[$];

   phase_type   phase_s;
   logic [15:0] remaining;
   logic [7:0]  pos_in_field;
   logic [7:0]  field_len;
   logic [7:0]  snpa_remaining;
   logic [15:0] afi_s;
   logic [7:0]  safi_s;
   logic [7:0]  pfx_bits_s;
   logic        short_s;
   logic [1:0]  err_s;
   logic        local_next;

   function automatic logic field_step();
      pos_in_field = pos_in_field + 8'd1;
      if (pos_in_field >= field_len) begin
         pos_in_field = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void hop_done();
      if (short_s) begin
         phase_s = PH_DISCARD;
      end else begin
         phase_s = PH_SNPACNT;
      end
   endfunction

   function automatic void snpa_entry_done();
      snpa_remaining = snpa_remaining - 8'd1;
      if (snpa_remaining != 8'd0) begin
         phase_s = PH_SNPALEN;
      end else begin
         phase_s = PH_PFXLEN;
      end
   endfunction

   task automatic classify_byte(input req_type r, output rsp_type res);
      logic [7:0] b;
      logic [3:0] cls;
      logic [4:0] idx;
      logic       last;
      logic       done;
      b = r.data_byte;
      cls = CLS_DISCARD;
      idx = 5'd0;
      last = 1'b0;
      done = 1'b0;
      if (r.start_of_attribute) begin
         remaining = (r.attribute_length == 16'd0) ? 16'd1 : r.attribute_length;
         pos_in_field = 8'd0;
         field_len = 8'd0;
         snpa_remaining = 8'd0;
         afi_s = 16'd0;
         safi_s = 8'd0;
         pfx_bits_s = 8'd0;
         err_s = ERR_NONE;
         local_next = 1'b0;
         short_s = (17'(remaining) == 17'(b) + 17'd1);
         if (short_s) begin
            phase_s = PH_HOPLEN;
         end else begin
            phase_s = PH_AFI0;
         end
      end
      if (phase_s != PH_IDLE) begin
         case (phase_s)
            PH_AFI0: begin
               cls = CLS_AFI;
               afi_s = {b, 8'h00};
               phase_s = PH_AFI1;
            end
            PH_AFI1: begin
               cls = CLS_AFI;
               idx = 5'd1;
               last = 1'b1;
               afi_s = afi_s | {8'h00, b};
               phase_s = PH_SAFI;
            end
            PH_SAFI: begin
               cls = CLS_SAFI;
               last = 1'b1;
               safi_s = b;
               phase_s = PH_HOPLEN;
            end
            PH_HOPLEN: begin
               cls = CLS_HOP_LEN;
               last = 1'b1;
               pos_in_field = 8'd0;
               local_next = (b == 8'd32);
               if (b == 8'd0) begin
                  hop_done();
               end else if (b == 8'd4 || b == 8'd16) begin
                  phase_s = PH_HOP;
                  field_len = b;
               end else if (b == 8'd32) begin
                  phase_s = PH_HOP;
                  field_len = 8'd16;
               end else begin
                  phase_s = PH_OTHER;
                  field_len = b;
               end
            end
            PH_HOP: begin
               cls = CLS_HOP;
               idx = pos_in_field[4:0];
               if (field_step()) begin
                  last = 1'b1;
                  if (local_next) begin
                     local_next = 1'b0;
                     phase_s = PH_LOCAL;
                     field_len = 8'd16;
                  end else begin
                     hop_done();
                  end
               end
            end
            PH_LOCAL, PH_OTHER: begin
               cls = (phase_s == PH_LOCAL) ? CLS_LOCAL_HOP : CLS_OTHER_HOP;
               idx = pos_in_field[4:0];
               if (field_step()) begin
                  last = 1'b1;
                  hop_done();
               end
            end
            PH_SNPACNT: begin
               cls = CLS_SNPA_CNT;
               last = 1'b1;
               snpa_remaining = b;
               if (b != 8'd0) begin
                  phase_s = PH_SNPALEN;
               end else begin
                  phase_s = PH_PFXLEN;
               end
            end
            PH_SNPALEN: begin
               cls = CLS_SNPA_LEN;
               last = 1'b1;
               if (b != 8'd0) begin
                  phase_s = PH_SNPABYTE;
                  field_len = b;
                  pos_in_field = 8'd0;
               end else begin
                  snpa_entry_done();
               end
            end
            PH_SNPABYTE: begin
               cls = CLS_SNPA_BYTE;
               idx = pos_in_field[4:0];
               if (field_step()) begin
                  last = 1'b1;
                  snpa_entry_done();
               end
            end
            PH_PFXLEN: begin
               cls = CLS_PFX_LEN;
               pfx_bits_s = b;
               if (b > MAX_PREFIX_BITS) begin
                  err_s = ERR_PFX_LONG;
                  phase_s = PH_DISCARD;
               end else if (b == 8'd0) begin
                  last = 1'b1;
               end else begin
                  phase_s = PH_PFXBYTE;
                  field_len = 8'((9'(b) + 9'd7) >> 3);
                  pos_in_field = 8'd0;
               end
            end
            PH_PFXBYTE: begin
               cls = CLS_PFX_BYTE;
               idx = pos_in_field[4:0];
               if (field_step()) begin
                  last = 1'b1;
                  phase_s = PH_PFXLEN;
               end
            end
            default: begin
               cls = CLS_DISCARD;
            end
         endcase
         remaining = remaining - 16'd1;
         if (remaining == 16'd0) begin
            done = 1'b1;
            if (phase_s != PH_PFXLEN && phase_s != PH_DISCARD && err_s == ERR_NONE) begin
               err_s = ERR_TRUNCATED;
            end
            phase_s = PH_IDLE;
         end
      end
      res = '{byte_class: cls, index_in_field: idx, afi_value: afi_s, safi_value: safi_s,
              prefix_bits: pfx_bits_s, field_last: last, short_form: short_s,
              error_code: err_s, attribute_done: done};
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         classified_q.delete();
         phase_s = PH_IDLE;
         remaining = 16'd0;
         pos_in_field = 8'd0;
         field_len = 8'd0;
         snpa_remaining = 8'd0;
         afi_s = 16'd0;
         safi_s = 8'd0;
         pfx_bits_s = 8'd0;
         short_s = 1'b0;
         err_s = ERR_NONE;
         local_next = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (classified_q.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h", $time, rsp_data);
               fails++;
            end else begin
               want = classified_q.pop_front();
               check_field("byte_class", 16'(want.byte_class), 16'(rsp_data.byte_class));
               check_field("index_in_field", 16'(want.index_in_field),
                           16'(rsp_data.index_in_field));
               check_field("afi_value", want.afi_value, rsp_data.afi_value);
               check_field("safi_value", 16'(want.safi_value), 16'(rsp_data.safi_value));
               check_field("prefix_bits", 16'(want.prefix_bits), 16'(rsp_data.prefix_bits));
               check_field("field_last", 16'(want.field_last), 16'(rsp_data.field_last));
               check_field("short_form", 16'(want.short_form), 16'(rsp_data.short_form));
               check_field("error_code", 16'(want.error_code), 16'(rsp_data.error_code));
               check_field("attribute_done", 16'(want.attribute_done),
                           16'(rsp_data.attribute_done));
            end
         end
         if (req_valid && !req_stall) begin
            classify_byte(req_data, want);
            classified_q.insert(classified_q.size(), want);
         end
      end
      pending = classified_q.size();
   end

endmodule
`default_nettype wire

/* tb/tb_mp_reach_attribute_parser_core.sv */
`default_nettype none
module tb_mp_reach_attribute_parser_core;
   import mpr_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      check_fails;
   int      check_pending;

   logic [7:0]  value_q[$];
   int unsigned value_bytes = 0;
   logic        no_send_gaps = 1'b0;
   logic        no_rsp_stalls = 1'b0;

   mp_reach_attribute_parser_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mp_reach_attribute_parser_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .fails     (check_fails),
      .pending   (check_pending)
   );

   always #4 clock = ~clock;

   initial begin
      #4000000;
      $display("mp_reach_attribute_parser_core regression: fail");
      $finish;
   end

   task automatic push_item(input logic [7:0] b, input logic st, input logic [15:0] len);
      int unsigned gap;
      gap = no_send_gaps ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, start_of_attribute: st, attribute_length: len};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic push_rand(input int unsigned n);
      repeat (n) value_q.insert(value_q.size(), 8'($urandom));
   endtask

   // Sends the built value under a declared length; bytes past a short length are dropped.
   task automatic send_value(input int unsigned declared);
      int unsigned n;
      n = (declared == 0) ? 1 : declared;
      if (n > value_q.size()) n = value_q.size();
      for (int i = 0; i < n; i++) begin
         push_item(value_q[i], i == 0, (i == 0) ? 16'(declared) : 16'($urandom));
      end
      value_bytes += n;
      value_q.delete();
   endtask

   function automatic int unsigned rand_hop_len();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 6) return 4;
      if (sel < 12) return 16;
      if (sel < 17) return 32;
      if (sel == 17) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 255);
      return $urandom_range(1, 40);
   endfunction

   initial begin
      int unsigned sel, size, declared, hop_len, entries, ent_len, prefixes, bits;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      no_send_gaps = 1'b1;
      push_item(8'hFF, 1'b0, 16'hFFFF);
      value_q = '{8'h04, 8'h00, 8'hFF, 8'h5A, 8'hA5};
      send_value(5);
      value_q = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h81, 8'hAB};
      send_value(8);
      value_q = '{8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h01, 8'h02};
      send_value(6);
      value_q = '{8'h00, 8'h02};
      send_value(65535);
      no_send_gaps = 1'b0;
      value_q = '{8'hFF};
      send_value(0);
      value_q = '{8'h00};
      send_value(0);

      // random
      while (value_bytes < 1650) begin
         if ($urandom_range(0, 7) == 0) no_send_gaps = ~no_send_gaps;
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 16'($urandom));
         end else begin
            if (sel < 25) begin
               hop_len = rand_hop_len();
               value_q.insert(value_q.size(), 8'(hop_len));
               push_rand(hop_len);
            end else begin
               if ($urandom_range(0, 1) != 0) begin
                  value_q.insert(value_q.size(), 8'h00);
                  value_q.insert(value_q.size(), 8'($urandom_range(1, 2)));
               end else begin
                  push_rand(2);
               end
               push_rand(1);
               hop_len = rand_hop_len();
               value_q.insert(value_q.size(), 8'(hop_len));
               push_rand(hop_len);
               entries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
               value_q.insert(value_q.size(), 8'(entries));
               repeat (entries) begin
                  ent_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 6);
                  value_q.insert(value_q.size(), 8'(ent_len));
                  push_rand(ent_len);
               end
               prefixes = $urandom_range(0, 4);
               for (int i = 0; i < prefixes; i++) begin
                  case ($urandom_range(0, 15))
                     0: bits = 0;
                     1: bits = MAX_PREFIX_BITS;
                     2: bits = $urandom_range(MAX_PREFIX_BITS + 1, 255);
                     3, 4, 5: bits = $urandom_range(1, MAX_PREFIX_BITS);
                     default: bits = $urandom_range(1, 32);
                  endcase
                  value_q.insert(value_q.size(), 8'(bits));
                  if (bits > MAX_PREFIX_BITS) begin
                     push_rand($urandom_range(0, 3));
                     break;
                  end
                  push_rand((bits + 7) / 8);
               end
            end
            size = value_q.size();
            declared = size;
            if (sel >= 85) begin
               if ($urandom_range(0, 1) != 0 && size > 1) begin
                  declared = $urandom_range(1, size - 1);
               end else begin
                  declared = size + $urandom_range(1, 300);
                  if ($urandom_range(0, 7) == 0) declared = 65535;
               end
               if ($urandom_range(0, 9) == 0) declared = 0;
            end
            send_value(declared);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (check_pending != 0);
      repeat (8) @(posedge clock);
      if (check_fails == 0) begin
         $display("mp_reach_attribute_parser_core regression: pass");
      end else begin
         $display("mp_reach_attribute_parser_core regression: fail");
      end
      $finish;
   end

   initial begin
      int unsigned stall_len;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) no_rsp_stalls = ~no_rsp_stalls;
         stall_len = no_rsp_stalls ? 0 : $urandom_range(0, 16);
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

endmodule
`default_nettype wire

/* mp_reach_attribute_parser_core.f */
rtl/core/mpr_pkg.sv
rtl/core/mpr_parser.sv
rtl/core/mpr_rsp_stage.sv
rtl/core/mp_reach_attribute_parser_core.sv
tb/mp_reach_attribute_parser_checker.sv
tb/tb_mp_reach_attribute_parser_core.sv
